[src/fifo_with_match_count_and_filter_defines.svh]
// Assertion macros shared by the match-count FIFO RTL.
`ifndef FIFO_WITH_MATCH_COUNT_AND_FILTER_DEFINES_SVH
`define FIFO_WITH_MATCH_COUNT_AND_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FWMCF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FWMCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FWMCF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define FWMCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/fwmcf_pkg.sv]
// Shared codes, controller states and control/status structs for the match-count FIFO.
package fwmcf_pkg;

  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;

  localparam logic [KIND_BITS-1:0] OP_ENQ    = 3'd0;
  localparam logic [KIND_BITS-1:0] OP_DEQ    = 3'd1;
  localparam logic [KIND_BITS-1:0] OP_FRONT  = 3'd2;
  localparam logic [KIND_BITS-1:0] OP_COUNT  = 3'd3;
  localparam logic [KIND_BITS-1:0] OP_REMOVE = 3'd4;
  localparam logic [KIND_BITS-1:0] OP_FIND   = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture the request payload
    logic start;     // clear scan counters
    logic scan;      // walk the stored entries
    logic rd_front;  // read the head entry
    logic commit;    // apply the state update and load the result register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_scan_op;
    logic is_front;
    logic empty;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

[src/fwmcf_req_if.sv]
// Request channel: operation kind and value with a valid/ready handshake.
interface fwmcf_req_if #(
  parameter int VALUE_BITS = 8
);
  logic                                valid;
  logic                                ready;
  logic [fwmcf_pkg::KIND_BITS-1:0]     kind;
  logic [VALUE_BITS-1:0]               value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

[src/fwmcf_rsp_if.sv]
// Result channel: status, front value, counts and occupancy with a valid/ready handshake.
interface fwmcf_rsp_if #(
  parameter int VALUE_BITS = 8,
  parameter int COUNT_BITS = 5,
  parameter int POS_BITS   = 4
);
  logic                                valid;
  logic                                ready;
  logic [fwmcf_pkg::STATUS_BITS-1:0]   status;
  logic [VALUE_BITS-1:0]               front_value;
  logic [COUNT_BITS-1:0]               match_count;
  logic [POS_BITS-1:0]                 position;
  logic [COUNT_BITS-1:0]               occupancy;

  modport source (output valid, status, front_value, match_count, position, occupancy,
                  input ready);
  modport sink   (input valid, status, front_value, match_count, position, occupancy,
                  output ready);
endinterface

[src/fwmcf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fwmcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fwmcf_ctrl.sv]
// Controller state machine: sequences accept, dispatch, entry scan and result commit.
module fwmcf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fwmcf_pkg::stat_t  stat,
  output fwmcf_pkg::ctl_t   ctl
);

  fwmcf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwmcf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fwmcf_pkg::S_IDLE: begin
        if (in_valid) state_next = fwmcf_pkg::S_DISPATCH;
      end
      fwmcf_pkg::S_DISPATCH: begin
        if (!stat.empty && stat.is_scan_op) state_next = fwmcf_pkg::S_SCAN;
        else                                 state_next = fwmcf_pkg::S_FINISH;
      end
      fwmcf_pkg::S_SCAN: begin
        if (stat.scan_done) state_next = fwmcf_pkg::S_FINISH;
      end
      fwmcf_pkg::S_FINISH: begin
        if (stat.out_free) state_next = fwmcf_pkg::S_IDLE;
      end
      default: state_next = fwmcf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctl          = '0;
    unique case (state)
      fwmcf_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
      end
      fwmcf_pkg::S_DISPATCH: begin
        ctl.start    = 1'b1;
        // head read lands in the RAM output register for the finish cycle
        ctl.rd_front = stat.is_front && !stat.empty;
      end
      fwmcf_pkg::S_SCAN: begin
        ctl.scan = 1'b1;
      end
      fwmcf_pkg::S_FINISH: begin
        ctl.commit = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

[src/fwmcf_dp.sv]
// Datapath: circular entry store, head/fill pointers, scan counters and result register.
module fwmcf_dp #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 8,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fwmcf_pkg::ctl_t                    ctl,
  output fwmcf_pkg::stat_t                   stat,
  input  logic [fwmcf_pkg::KIND_BITS-1:0]    in_kind,
  input  logic [VALUE_BITS-1:0]              in_value,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [fwmcf_pkg::STATUS_BITS-1:0]  out_status,
  output logic [VALUE_BITS-1:0]              out_front,
  output logic [CW-1:0]                      out_match,
  output logic [AW-1:0]                      out_pos,
  output logic [CW-1:0]                      out_occ
);

  localparam int SW = AW + 1;
  localparam logic [CW-1:0] FULL_LEVEL = CW'(DEPTH);

  // store index of an entry given its distance from the head
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]                     head, head_next;
  logic [CW-1:0]                     fill, fill_next;
  logic [fwmcf_pkg::KIND_BITS-1:0]   kind_r;
  logic [VALUE_BITS-1:0]             value_r;
  logic [CW-1:0]                     scan_idx;
  logic                              cmp_valid;
  logic [AW-1:0]                     cmp_idx;
  logic [CW-1:0]                     wr_idx;
  logic [CW-1:0]                     hit_total;
  logic                              found;
  logic [AW-1:0]                     pos;

  logic [fwmcf_pkg::STATUS_BITS-1:0] r_status;
  logic [VALUE_BITS-1:0]             r_front;
  logic [CW-1:0]                     r_match;
  logic [AW-1:0]                     r_pos;

  logic                              ram_we, ram_re;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0]             ram_wdata, ram_rdata;

  logic hit, scan_issue, scan_wr, enq_wr;

  assign hit        = (ram_rdata == value_r);
  assign scan_issue = ctl.scan && (scan_idx != fill);
  // compaction: kept entries move down to the write offset, order preserved
  assign scan_wr    = ctl.scan && cmp_valid && (kind_r == fwmcf_pkg::OP_REMOVE) && !hit;
  assign enq_wr     = ctl.commit && (kind_r == fwmcf_pkg::OP_ENQ) && (fill != FULL_LEVEL);

  assign ram_re    = scan_issue || ctl.rd_front;
  assign ram_raddr = ctl.rd_front ? head : slot_of(head, scan_idx);
  assign ram_we    = scan_wr || enq_wr;
  assign ram_waddr = scan_wr ? slot_of(head, wr_idx) : slot_of(head, fill);
  assign ram_wdata = scan_wr ? ram_rdata : value_r;

  fwmcf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.is_scan_op = (kind_r == fwmcf_pkg::OP_COUNT) ||
                           (kind_r == fwmcf_pkg::OP_REMOVE) ||
                           (kind_r == fwmcf_pkg::OP_FIND);
  assign stat.is_front   = (kind_r == fwmcf_pkg::OP_FRONT);
  assign stat.empty      = (fill == '0);
  assign stat.scan_done  = (scan_idx == fill) && !cmp_valid;
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    head_next = head;
    fill_next = fill;
    r_status  = fwmcf_pkg::ST_OK;
    r_front   = '0;
    r_match   = '0;
    r_pos     = '0;
    if (kind_r == fwmcf_pkg::OP_ENQ) begin
      if (fill == FULL_LEVEL) r_status  = fwmcf_pkg::ST_FULL;
      else                    fill_next = fill + CW'(1);
    end else if (kind_r <= fwmcf_pkg::OP_FIND) begin
      if (fill == '0) begin
        r_status = fwmcf_pkg::ST_EMPTY;
      end else begin
        unique case (kind_r)
          fwmcf_pkg::OP_DEQ: begin
            head_next = slot_of(head, CW'(1));
            fill_next = fill - CW'(1);
          end
          fwmcf_pkg::OP_FRONT: begin
            r_front = ram_rdata;
          end
          fwmcf_pkg::OP_COUNT: begin
            r_match = hit_total;
          end
          fwmcf_pkg::OP_REMOVE: begin
            r_match   = hit_total;
            fill_next = wr_idx;
            if (wr_idx == '0) head_next = '0;
          end
          fwmcf_pkg::OP_FIND: begin
            if (found) r_pos    = pos;
            else       r_status = fwmcf_pkg::ST_NOTFOUND;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= scan_issue;
      if (ctl.commit) begin
        head      <= head_next;
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (ctl.start) begin
      scan_idx  <= '0;
      wr_idx    <= '0;
      hit_total <= '0;
      found     <= 1'b0;
      pos       <= '0;
    end else if (ctl.scan) begin
      if (scan_issue) begin
        scan_idx <= scan_idx + CW'(1);
        cmp_idx  <= scan_idx[AW-1:0];
      end
      if (cmp_valid) begin
        if (hit) begin
          hit_total <= hit_total + CW'(1);
          if (!found) begin
            found <= 1'b1;
            pos   <= cmp_idx;
          end
        end else begin
          wr_idx <= wr_idx + CW'(1);
        end
      end
    end
    if (ctl.commit) begin
      out_status <= r_status;
      out_front  <= r_front;
      out_match  <= r_match;
      out_pos    <= r_pos;
      out_occ    <= fill_next;
    end
  end

endmodule

[src/fifo_with_match_count_and_filter.sv]
// Bounded FIFO of small values with count, remove-all and find operations.
//
// req channel carries one operation (kind) and a value; rsp returns exactly one
// result per request: status, front value, match count, position, occupancy.
// Handshakes are valid/ready; a transfer happens when both are high.
// One request is in work at a time. Enqueue, dequeue, read front and unused
// kinds go from transfer to result valid through accept, dispatch and commit.
// Count, remove and find walk the stored entries through the single RAM read
// port, one entry per cycle, between dispatch and commit; the next request is
// taken the cycle after the result is loaded.
// Remove compacts the survivors in place through the RAM write port during
// the same walk.
// The result sits in an output register: a stalled receiver does not block the
// next request, only the commit of its result, which waits until the register
// frees up.
// Reset (synchronous, active high) empties the queue and drops any pending
// result; the entry store itself is not cleared and needs no clearing pass.
module fifo_with_match_count_and_filter #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 8
) (
  input logic             clk,
  input logic             rst,
  fwmcf_req_if.sink       req,
  fwmcf_rsp_if.source     rsp
);

  `include "fifo_with_match_count_and_filter_defines.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] OCC_FULL = CW'(DEPTH);

  fwmcf_pkg::ctl_t  ctl;
  fwmcf_pkg::stat_t stat;

  fwmcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  fwmcf_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .in_kind    (req.kind),
    .in_value   (req.value),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_status (rsp.status),
    .out_front  (rsp.front_value),
    .out_match  (rsp.match_count),
    .out_pos    (rsp.position),
    .out_occ    (rsp.occupancy)
  );

  `FWMCF_ASSERT_NEXT(a_one_in_work, clk, rst, req.valid && req.ready, !req.ready, "request taken while busy")
  `FWMCF_ASSERT_SAME(a_commit_free, clk, rst, ctl.commit, !rsp.valid || rsp.ready, "result overwritten")
  `FWMCF_ASSERT_SAME(a_full_occ, clk, rst, rsp.valid && rsp.status == fwmcf_pkg::ST_FULL, rsp.occupancy == OCC_FULL, "full status without full queue")
  `FWMCF_ASSERT_SAME(a_empty_res, clk, rst, rsp.valid && rsp.status == fwmcf_pkg::ST_EMPTY, rsp.occupancy == '0 && rsp.match_count == '0, "empty status with entries")

endmodule
